### hdl/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BASE_W  = 4;

  localparam logic [BASE_W-1:0] BASE_MIN      = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX      = 4'd10;
  localparam logic [BASE_W-1:0] RST_IN_BASE   = 4'd8;
  localparam logic [BASE_W-1:0] RST_OUT_BASE  = 4'd9;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_IN_BASE  = 1'b0;
  localparam logic [0:0] REG_OUT_BASE = 1'b1;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_out;
    logic               last_out;
    logic               overflow;
  } out_word_t;

  // out of range bases act as the nearest legal one
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rdc_front.sv
`default_nettype none

module rdc_front #(
  parameter int unsigned ACC_BITS = 63
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [3:0]              in_base,
  input  wire logic                    accept,
  input  wire rdc_pkg::in_word_t       in_data,
  output logic                         q_push,
  output logic [ACC_BITS:0]            q_data
);
  import rdc_pkg::*;

  localparam int unsigned PW = ACC_BITS + 4;

  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PW-1:0]       prod;
  logic [BASE_W-1:0]   ib;
  logic                sat;
  logic [ACC_BITS-1:0] acc_new;
  logic                ovf_new;

  always_comb begin
    ib      = clamp_base(in_base);
    prod    = PW'(acc_r) * PW'(ib) + PW'(in_data.digit_in);
    sat     = (prod[PW-1:ACC_BITS] != 4'd0);
    acc_new = sat ? {ACC_BITS{1'b1}} : prod[ACC_BITS-1:0];
    ovf_new = ovf_r | sat;
  end

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_data.last_in) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        acc_nxt = acc_new;
        ovf_nxt = ovf_new;
      end
    end
  end

  assign q_push = accept & in_data.last_in;
  assign q_data = {ovf_new, acc_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/rdc_fifo.sv
`default_nettype none

module rdc_fifo #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/rdc_back.sv
`default_nettype none

module rdc_back #(
  parameter int unsigned ACC_BITS   = 63,
  parameter int unsigned MAX_DIGITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         out_base,
  input  wire logic               job_valid,
  input  wire logic [ACC_BITS:0]  job_data,
  output logic                    job_pop,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output rdc_pkg::out_word_t      out_data
);
  import rdc_pkg::*;

  localparam int unsigned DIV_W = ((ACC_BITS + 3) / 4) * 4;
  localparam int unsigned STEPS = DIV_W / 4;
  localparam int unsigned SW    = $clog2(STEPS);
  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned CW    = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [DIV_W-1:0]   val_r, val_nxt;
  logic               ovf_r, ovf_nxt;
  logic [BASE_W-1:0]  ob_r, ob_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               rd_pend_r;
  logic               rd_last_r, rd_last_nxt;
  logic               issued_r, issued_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;
  logic [3:0]         rd_data_r;
  logic [3:0]         mem [MAX_DIGITS];

  logic [3:0]         r;
  logic [4:0]         t;
  logic [3:0]         qb;
  logic [DIV_W-1:0]   quot;
  logic               fin;
  logic [CW-1:0]      n_inc;
  logic               mem_we;
  logic               issue;

  // four restoring division steps per cycle, msb first
  always_comb begin
    r  = rem_r;
    t  = '0;
    qb = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r, val_r[DIV_W-1-i]};
      if (t >= {1'b0, ob_r}) begin
        r         = 4'(t - {1'b0, ob_r});
        qb[3-i]   = 1'b1;
      end else begin
        r = t[3:0];
      end
    end
    quot  = {val_r[DIV_W-5:0], qb};
    fin   = (step_r == SW'(STEPS - 1));
    n_inc = n_r + CW'(1);
  end

  assign job_pop = (state_r == ST_IDLE) && job_valid;
  assign mem_we  = (state_r == ST_DIV) && fin;
  assign issue   = (state_r == ST_EMIT) && !issued_r && !rd_pend_r
                   && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    ovf_nxt     = ovf_r;
    ob_nxt      = ob_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    n_nxt       = n_r;
    rd_idx_nxt  = rd_idx_r;
    rd_last_nxt = rd_last_r;
    issued_nxt  = issued_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          val_nxt   = DIV_W'(job_data[ACC_BITS-1:0]);
          ovf_nxt   = job_data[ACC_BITS];
          ob_nxt    = clamp_base(out_base);
          rem_nxt   = '0;
          step_nxt  = '0;
          n_nxt     = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        val_nxt = quot;
        if (fin) begin
          rem_nxt  = '0;
          step_nxt = '0;
          n_nxt    = n_inc;
          // a zero quotient or a full store ends the digit string; zero itself gives one digit
          if ((quot == '0) || (n_inc == CW'(MAX_DIGITS))) begin
            state_nxt  = ST_EMIT;
            rd_idx_nxt = n_r[AW-1:0];
            issued_nxt = 1'b0;
          end
        end else begin
          rem_nxt  = r;
          step_nxt = step_r + SW'(1);
        end
      end
      ST_EMIT: begin
        if (issue) begin
          rd_last_nxt = (rd_idx_r == '0);
          issued_nxt  = (rd_idx_r == '0);
          rd_idx_nxt  = rd_idx_r - AW'(1);
        end
        if (rd_pend_r && rd_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // digit store, most significant digit read back first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[n_r[AW-1:0]] <= r;
    end
    if (issue) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    ovf_r     <= ovf_nxt;
    ob_r      <= ob_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    n_r       <= n_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_last_r <= rd_last_nxt;
    if (rd_pend_r) begin
      out_word_r.digit_out <= rd_data_r;
      out_word_r.last_out  <= rd_last_r;
      out_word_r.overflow  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= issue;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_word_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < ob_r)) else $error("remainder not below base");

  a_slot_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r) else $error("read data lands on a full output slot");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (n_r < CW'(MAX_DIGITS))) else $error("digit store overrun");

endmodule

`default_nettype wire

### hdl/radix_digit_converter_core.sv
`default_nettype none

// radix digit converter: digits of a number in base in_base come in msb first, one word per
// push; each is folded into a saturating accumulator (value * in_base + digit). the word
// marked last_in hands the finished value (and its sticky overflow flag) through a two-entry
// queue to the conversion engine, so the front keeps taking digits of the next number while
// the previous one is converted. conversion divides by out_base four bits per cycle, and the
// digits, collected lsb first into a MAX_DIGITS-deep store, are then played out msb first
// through a one-word output register. the engine takes the next number from the queue only
// once the last digit of the current one has been read from the store; push is held off
// (full high) only while the queue already holds two waiting numbers. zero gives the single
// digit 0, the final word carries last_out, and every word of a number carries its overflow
// flag. bases outside 2..10 act as the nearest legal base; registers sit at byte address 0
// (in_base) and 4 (out_base) and should be written while idle.

module radix_digit_converter_core #(
  parameter int unsigned ACC_BITS   = 63,
  parameter int unsigned MAX_DIGITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input digits
  input  wire logic                push,
  input  wire rdc_pkg::in_word_t   in_data,
  output logic                     full,
  // output digits
  input  wire logic                pop,
  output rdc_pkg::out_word_t       out_data,
  output logic                     empty,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import rdc_pkg::*;

  logic [BASE_W-1:0] in_base_r;
  logic [BASE_W-1:0] out_base_r;
  logic              cfg_wr;

  logic              accept;
  logic              q_push;
  logic [ACC_BITS:0] q_wdata;
  logic              q_full;
  logic              q_pop;
  logic [ACC_BITS:0] q_rdata;
  logic              q_empty;
  logic              out_pop;

  // ---- configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_base_r  <= RST_IN_BASE;
      out_base_r <= RST_OUT_BASE;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IN_BASE:  in_base_r  <= pwdata[BASE_W-1:0];
        REG_OUT_BASE: out_base_r <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback, raw bits as written
  always_comb begin
    unique case (paddr[2])
      REG_IN_BASE:  prdata = 32'(in_base_r);
      REG_OUT_BASE: prdata = 32'(out_base_r);
      default:      prdata = '0;
    endcase
  end

  // ---- front: digit accumulation
  assign full   = q_full;
  assign accept = push & ~q_full;

  rdc_front #(
    .ACC_BITS (ACC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_base (in_base_r),
    .accept  (accept),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // ---- finished values waiting for conversion
  rdc_fifo #(
    .W (ACC_BITS + 1)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // ---- back: division and digit play-out
  assign out_pop = pop & ~empty;

  rdc_back #(
    .ACC_BITS   (ACC_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_base  (out_base_r),
    .job_valid (~q_empty),
    .job_data  (q_rdata),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
